>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file that checks itself
// no dependencies; each macro expands to one concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/ab2av_pkg.sv
// shared types and constants of the annex b to avcc nal splitter
// no dependencies; imported by every module of the block
package ab2av_pkg;

  // start code scanner phase
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_HEADER = 2'd1,
    PH_INSIDE = 2'd2
  } phase_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_NAL_END  = 2'd1,
    KIND_UNIT_END = 2'd2
  } kind_e;

  // nal routing
  typedef enum logic [1:0] {
    ROUTE_SAMPLE = 2'd0,
    ROUTE_SPS    = 2'd1,
    ROUTE_PPS    = 2'd2,
    ROUTE_DROP   = 2'd3
  } route_e;

  localparam logic [7:0] TYPE_MASK = 8'h1F;
  localparam logic [4:0] TYPE_SEI  = 5'd6;
  localparam logic [4:0] TYPE_SPS  = 5'd7;
  localparam logic [4:0] TYPE_PPS  = 5'd8;

  // work queue between scanner and sequencer
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // work for one input word, carried out in field order
  typedef struct packed {
    logic       hdr;    // commit data as a nal header
    logic [2:0] zeros;  // held zeros to commit
    logic       lit;    // commit data as a nal byte
    logic [7:0] data;
    logic       endn;   // close the open nal
    logic       unit;   // close the access unit
    logic       key;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic route_e route_of(logic [4:0] t);
    route_e r;
    r = ROUTE_SAMPLE;
    if (t == TYPE_SPS) r = ROUTE_SPS;
    else if (t == TYPE_PPS) r = ROUTE_PPS;
    else if (t == TYPE_SEI) r = ROUTE_DROP;
    return r;
  endfunction

endpackage

>>> rtl/ab2av_front.sv
// start code scanner: classifies each input word into at most one work entry
// depends on ab2av_pkg
module ab2av_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  logic              unit_last_i,
  input  logic              key_frame_i,
  input  logic              accept_i,
  output ab2av_pkg::entry_t entry_o,
  output logic              entry_valid_o
);
  import ab2av_pkg::*;

  phase_e     phase_q, phase_d, phase_nx;
  logic [1:0] held_q, held_d, held_nx;
  entry_t     e;

  // next state
  always_comb begin
    phase_nx = phase_q;
    held_nx  = held_q;
    case (phase_q)
      PH_HEADER: begin
        held_nx  = 2'd0;
        phase_nx = PH_INSIDE;
      end
      PH_INSIDE: begin
        if (data_byte_i == 8'h00) begin
          if (held_q != 2'd3) held_nx = held_q + 2'd1;
        end else if (data_byte_i == 8'h01 && held_q >= 2'd2) begin
          held_nx  = 2'd0;
          phase_nx = PH_HEADER;
        end else begin
          held_nx = 2'd0;
        end
      end
      default: begin
        phase_nx = PH_SEARCH;
        if (data_byte_i == 8'h00) begin
          held_nx = (held_q < 2'd2) ? held_q + 2'd1 : 2'd2;
        end else if (data_byte_i == 8'h01 && held_q >= 2'd2) begin
          held_nx  = 2'd0;
          phase_nx = PH_HEADER;
        end else begin
          held_nx = 2'd0;
        end
      end
    endcase
    phase_d = phase_q;
    held_d  = held_q;
    if (accept_i) begin
      if (unit_last_i) begin
        phase_d = PH_SEARCH;
        held_d  = 2'd0;
      end else begin
        phase_d = phase_nx;
        held_d  = held_nx;
      end
    end
  end

  // work entry for this word
  always_comb begin
    e      = '0;
    e.data = data_byte_i;
    e.key  = key_frame_i;
    case (phase_q)
      PH_HEADER: begin
        e.hdr = 1'b1;
      end
      PH_INSIDE: begin
        if (data_byte_i == 8'h00) begin
          // fourth zero pushes the oldest held zero into the nal
          if (held_q == 2'd3) e.zeros = 3'd1;
        end else if (data_byte_i == 8'h01 && held_q >= 2'd2) begin
          e.endn = 1'b1;
        end else begin
          e.zeros = {1'b0, held_q};
          e.lit   = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // unit end inside a nal keeps the held zeros
    if (unit_last_i) begin
      e.unit = 1'b1;
      if (phase_nx == PH_INSIDE) begin
        e.zeros = e.zeros + {1'b0, held_nx};
        e.endn  = 1'b1;
      end
    end
  end

  assign entry_o       = e;
  assign entry_valid_o = e.hdr | e.lit | e.endn | e.unit | (e.zeros != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      held_q  <= 2'd0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

>>> rtl/ab2av_fifo.sv
// short work queue between the scanner and the sequencer
// depends on ab2av_pkg
module ab2av_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ab2av_pkg::entry_t  entry_i,
  input  logic               pop_i,
  output ab2av_pkg::entry_t  entry_o,
  output ab2av_pkg::q_stat_t stat_o
);
  import ab2av_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = mem_q[rd_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + QCNT_W'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= wr_q + QPTR_W'(1);
      if (do_pop) rd_q <= rd_q + QPTR_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

endmodule

>>> rtl/ab2av_back.sv
// sequencer: carries out queued work one operation per cycle unless a stalled result
// port holds it, keeps nal and unit state and the result register; depends on ab2av_pkg
module ab2av_back #(
  parameter int LENGTH_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ab2av_pkg::entry_t  head_i,
  input  ab2av_pkg::q_stat_t qstat_i,
  output logic               qpop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [1:0]         kind_o,
  output logic [7:0]         out_byte_o,
  output logic [4:0]         unit_type_o,
  output logic [1:0]         route_o,
  output logic [23:0]        nal_length_o,
  output logic [23:0]        frame_length_o,
  output logic               write_sample_o,
  output logic               key_out_o,
  output logic               params_changed_o,
  output logic [23:0]        sps_info_o,
  output logic               run_last_o
);
  import ab2av_pkg::*;

  typedef enum logic [2:0] {
    OP_HDR, OP_ZERO, OP_LIT, OP_END, OP_UNIT
  } op_e;

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  // working entry
  entry_t cur_q, cur_d, rem;
  logic   cur_valid_q, cur_valid_d;

  // nal and unit state
  logic [4:0]             type_q, type_d;
  logic [LENGTH_BITS-1:0] nal_q, nal_d;
  logic [LENGTH_BITS-1:0] frame_q, frame_d;
  logic                   sps_pres_q, sps_pres_d, pps_pres_q, pps_pres_d;
  logic                   chg_q, chg_d;
  logic [23:0]            sps_q, sps_d;

  // result register
  logic        ovalid_q, ovalid_d;
  kind_e       kind_q;
  logic [7:0]  byte_q;
  logic [4:0]  utype_q;
  route_e      route_q;
  logic [23:0] nlen_q, flen_q, sps_info_q;
  logic        ws_q, key_q, pc_q, rlast_q;

  op_e                    op;
  logic [4:0]             t_use;
  route_e                 rt;
  logic [LENGTH_BITS-1:0] nal_base, nal_inc, len4, frame_add;
  logic [LENGTH_BITS:0]   sum1, sum2;
  logic [7:0]             cbyte;
  logic [23:0]            sps_commit;
  logic                   is_commit, produces, go, out_free;
  logic                   rem_nonunit, rem_empty, more;
  logic [LENGTH_BITS+23:0] nal_ext, frame_ext;

  // pick the next operation of the working entry
  always_comb begin
    if (cur_q.hdr) op = OP_HDR;
    else if (cur_q.zeros != 3'd0) op = OP_ZERO;
    else if (cur_q.lit) op = OP_LIT;
    else if (cur_q.endn) op = OP_END;
    else op = OP_UNIT;
  end

  assign is_commit = (op == OP_HDR) || (op == OP_ZERO) || (op == OP_LIT);
  assign t_use     = (op == OP_HDR) ? 5'(cur_q.data & TYPE_MASK) : type_q;
  assign rt        = route_of(t_use);
  assign nal_base  = (op == OP_HDR) ? '0 : nal_q;
  assign cbyte     = (op == OP_ZERO) ? 8'h00 : cur_q.data;
  assign nal_inc   = (nal_base == LenMax) ? nal_base : nal_base + LENGTH_BITS'(1);

  // sps bytes one to three land in the info word
  always_comb begin
    sps_commit = ((op == OP_HDR) && (t_use == TYPE_SPS)) ? 24'h0 : sps_q;
    if (t_use == TYPE_SPS && nal_base[LENGTH_BITS-1:2] == '0) begin
      case (nal_base[1:0])
        2'd1:    sps_commit[23:16] = cbyte;
        2'd2:    sps_commit[15:8]  = cbyte;
        2'd3:    sps_commit[7:0]   = cbyte;
        default: begin
        end
      endcase
    end
  end

  // saturating frame length: frame + (4 + nal)
  assign sum1      = {1'b0, nal_q} + (LENGTH_BITS+1)'(4);
  assign len4      = sum1[LENGTH_BITS] ? LenMax : sum1[LENGTH_BITS-1:0];
  assign sum2      = {1'b0, frame_q} + {1'b0, len4};
  assign frame_add = sum2[LENGTH_BITS] ? LenMax : sum2[LENGTH_BITS-1:0];
  assign nal_ext   = {24'h0, nal_q};
  assign frame_ext = {24'h0, frame_q};

  // issue control
  assign produces = (op == OP_UNIT) || (rt != ROUTE_DROP);
  assign out_free = !ovalid_q || pop_i;
  assign go       = cur_valid_q && (!produces || out_free);

  // what is left of the entry after this operation
  always_comb begin
    rem = cur_q;
    case (op)
      OP_HDR:  rem.hdr   = 1'b0;
      OP_ZERO: rem.zeros = cur_q.zeros - 3'd1;
      OP_LIT:  rem.lit   = 1'b0;
      OP_END:  rem.endn  = 1'b0;
      default: rem.unit  = 1'b0;
    endcase
  end

  assign rem_nonunit = rem.hdr | rem.lit | rem.endn | (rem.zeros != 3'd0);
  assign rem_empty   = !rem_nonunit && !rem.unit;
  assign more        = rem.unit | (rem_nonunit & (rt != ROUTE_DROP));

  // working entry and queue pop
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    qpop_o      = 1'b0;
    if (!cur_valid_q || (go && rem_empty)) begin
      cur_d       = head_i;
      cur_valid_d = !qstat_i.empty;
      qpop_o      = !qstat_i.empty;
    end else if (go) begin
      cur_d = rem;
    end
  end

  // state update
  always_comb begin
    type_d     = type_q;
    nal_d      = nal_q;
    frame_d    = frame_q;
    sps_pres_d = sps_pres_q;
    pps_pres_d = pps_pres_q;
    chg_d      = chg_q;
    sps_d      = sps_q;
    if (go) begin
      if (is_commit) begin
        type_d = t_use;
        nal_d  = nal_inc;
        sps_d  = sps_commit;
      end else if (op == OP_END) begin
        case (rt)
          ROUTE_SAMPLE: frame_d = frame_add;
          ROUTE_SPS: begin
            sps_pres_d = 1'b1;
            chg_d      = 1'b1;
          end
          ROUTE_PPS: begin
            pps_pres_d = 1'b1;
            chg_d      = 1'b1;
          end
          default: begin
          end
        endcase
        nal_d = '0;
      end else begin
        frame_d = '0;
        chg_d   = 1'b0;
        nal_d   = '0;
        type_d  = 5'd0;
      end
    end
  end

  assign ovalid_d = (go && produces) ? 1'b1 : (pop_i ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      ovalid_q    <= 1'b0;
      type_q      <= 5'd0;
      nal_q       <= '0;
      frame_q     <= '0;
      sps_pres_q  <= 1'b0;
      pps_pres_q  <= 1'b0;
      chg_q       <= 1'b0;
      sps_q       <= 24'h0;
    end else begin
      cur_valid_q <= cur_valid_d;
      ovalid_q    <= ovalid_d;
      type_q      <= type_d;
      nal_q       <= nal_d;
      frame_q     <= frame_d;
      sps_pres_q  <= sps_pres_d;
      pps_pres_q  <= pps_pres_d;
      chg_q       <= chg_d;
      sps_q       <= sps_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (go && produces) begin
      kind_q     <= is_commit ? KIND_BYTE : ((op == OP_END) ? KIND_NAL_END : KIND_UNIT_END);
      byte_q     <= is_commit ? cbyte : 8'h00;
      utype_q    <= (op != OP_UNIT) ? t_use : 5'd0;
      route_q    <= (op != OP_UNIT) ? rt : ROUTE_SAMPLE;
      nlen_q     <= (op == OP_END) ? nal_ext[23:0] : 24'h0;
      flen_q     <= (op == OP_UNIT) ? frame_ext[23:0] : 24'h0;
      ws_q       <= (op == OP_UNIT) && (frame_q != '0) && sps_pres_q && pps_pres_q;
      key_q      <= (op == OP_UNIT) && cur_q.key;
      pc_q       <= (op == OP_UNIT) && chg_q;
      sps_info_q <= is_commit ? sps_commit : sps_q;
      rlast_q    <= !more;
    end
  end

  assign empty_o          = !ovalid_q;
  assign kind_o           = kind_q;
  assign out_byte_o       = byte_q;
  assign unit_type_o      = utype_q;
  assign route_o          = route_q;
  assign nal_length_o     = nlen_q;
  assign frame_length_o   = flen_q;
  assign write_sample_o   = ws_q;
  assign key_out_o        = key_q;
  assign params_changed_o = pc_q;
  assign sps_info_o       = sps_info_q;
  assign run_last_o       = rlast_q;

endmodule

>>> rtl/annexb_to_avcc_nal_splitter.sv
// channel   handshake          payload
// input     push_i / full_o    data_byte_i, unit_last_i, key_frame_i
// result    pop_i / empty_o    kind_o .. run_last_o (one word per record)
//
// a word is taken every cycle while the work queue has room; the scanner
// turns it into at most one queue entry, and the sequencer carries out one
// operation (header, byte, held zero, nal end, unit end) per cycle unless a
// stalled result port holds an operation that produces a result. rst_ni
// clears all control and nal state at once. a stalled result port backs up
// the queue, then full_o rises.
// top level of the annex b to avcc nal splitter; depends on ab2av_pkg,
// ab2av_front, ab2av_fifo, ab2av_back and assert_macros.svh
`include "assert_macros.svh"

module annexb_to_avcc_nal_splitter #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  data_byte_i,
  input  logic        unit_last_i,
  input  logic        key_frame_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [4:0]  unit_type_o,
  output logic [1:0]  route_o,
  output logic [23:0] nal_length_o,
  output logic [23:0] frame_length_o,
  output logic        write_sample_o,
  output logic        key_out_o,
  output logic        params_changed_o,
  output logic [23:0] sps_info_o,
  output logic        run_last_o
);
  import ab2av_pkg::*;

  entry_t  f_entry, q_head;
  logic    f_valid, accept, q_push, q_pop;
  q_stat_t q_stat;

  assign full_o = q_stat.full;
  assign accept = push_i && !q_stat.full;
  assign q_push = accept && f_valid;

  // scanner
  ab2av_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .unit_last_i   (unit_last_i),
    .key_frame_i   (key_frame_i),
    .accept_i      (accept),
    .entry_o       (f_entry),
    .entry_valid_o (f_valid)
  );

  // work queue
  ab2av_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (f_entry),
    .pop_i   (q_pop),
    .entry_o (q_head),
    .stat_o  (q_stat)
  );

  // sequencer and result register
  ab2av_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (q_head),
    .qstat_i          (q_stat),
    .qpop_o           (q_pop),
    .pop_i            (pop_i),
    .empty_o          (empty_o),
    .kind_o           (kind_o),
    .out_byte_o       (out_byte_o),
    .unit_type_o      (unit_type_o),
    .route_o          (route_o),
    .nal_length_o     (nal_length_o),
    .frame_length_o   (frame_length_o),
    .write_sample_o   (write_sample_o),
    .key_out_o        (key_out_o),
    .params_changed_o (params_changed_o),
    .sps_info_o       (sps_info_o),
    .run_last_o       (run_last_o)
  );

  // checks
  `ASSERT_IMPL(a_no_push_when_full, clk_i, rst_ni, q_stat.full, !q_push)
  `ASSERT_IMPL(a_no_pop_when_empty, clk_i, rst_ni, q_pop, !q_stat.empty)
  `ASSERT_NEXT(a_unit_end_queued, clk_i, rst_ni, accept && unit_last_i, !q_stat.empty)

endmodule

>>> bench/tb_annexb_to_avcc_nal_splitter.sv
// testbench for the annex b to avcc nal splitter: directed access units, then random ones
// depends on ab2av_pkg and annexb_to_avcc_nal_splitter; self-checking, no files read
`timescale 1ns / 100ps

module tb_annexb_to_avcc_nal_splitter;
  import ab2av_pkg::*;

  localparam int LENGTH_BITS = 24;
  localparam longint unsigned LEN_CAP = (64'd1 << LENGTH_BITS) - 1;
  localparam int SETTLE_CYCLES = 40;

  // one result word as the block should give it
  typedef struct {
    kind_e       kind;
    logic [7:0]  data;
    logic [4:0]  hdr_type;
    route_e      path;
    logic [23:0] nal_len;
    logic [23:0] frame_len;
    logic        write_ok;
    logic        key;
    logic        changed;
    logic [23:0] sps_word;
    logic        last_of_word;
  } record_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        unit_last_i = 1'b0;
  logic        key_frame_i = 1'b0;
  logic        pop_i = 1'b0;
  logic        empty_o;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [4:0]  unit_type_o;
  logic [1:0]  route_o;
  logic [23:0] nal_length_o;
  logic [23:0] frame_length_o;
  logic        write_sample_o;
  logic        key_out_o;
  logic        params_changed_o;
  logic [23:0] sps_info_o;
  logic        run_last_o;

  annexb_to_avcc_nal_splitter #(
    .LENGTH_BITS(LENGTH_BITS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push_i),
    .full_o(full_o),
    .data_byte_i(data_byte_i),
    .unit_last_i(unit_last_i),
    .key_frame_i(key_frame_i),
    .pop_i(pop_i),
    .empty_o(empty_o),
    .kind_o(kind_o),
    .out_byte_o(out_byte_o),
    .unit_type_o(unit_type_o),
    .route_o(route_o),
    .nal_length_o(nal_length_o),
    .frame_length_o(frame_length_o),
    .write_sample_o(write_sample_o),
    .key_out_o(key_out_o),
    .params_changed_o(params_changed_o),
    .sps_info_o(sps_info_o),
    .run_last_o(run_last_o)
  );

  always #5 clk_i = ~clk_i;

  // splitter model state
  logic [7:0]      zero_hold [3] = '{8'h00, 8'h00, 8'h00};
  int unsigned     hold_n = 0;
  phase_e          scan = PH_SEARCH;
  logic [4:0]      open_type = '0;
  longint unsigned open_len = 0;
  longint unsigned unit_bytes = 0;
  bit              have_sps = 1'b0;
  bit              have_pps = 1'b0;
  bit              unit_params = 1'b0;
  logic [23:0]     sps_word = '0;
  record_t         expected_words[$];

  // bookkeeping
  int          errors = 0;
  int          words_sent = 0;
  int          units_sent = 0;
  int          n_payload = 0;
  int          n_nal_end = 0;
  int          n_unit_end = 0;
  int          n_written = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;
  logic [7:0]  stream_q[$];
  int          pop_cycle = 0;
  int          pop_mode = 0;
  int          pop_hold = 0;

  task automatic report(input string msg);
    errors++;
    if (errors <= 20) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic route_e path_for_type(logic [4:0] t);
    case (t)
      TYPE_SPS: return ROUTE_SPS;
      TYPE_PPS: return ROUTE_PPS;
      TYPE_SEI: return ROUTE_DROP;
      default:  return ROUTE_SAMPLE;
    endcase
  endfunction

  function automatic longint unsigned sat_len(longint unsigned a, longint unsigned b);
    return (a + b > LEN_CAP) ? LEN_CAP : a + b;
  endfunction

  function automatic void add_record(kind_e k, logic [7:0] d, logic [4:0] t, route_e r,
                                     longint unsigned nl, longint unsigned fl,
                                     bit ws, bit key, bit ch);
    record_t w;
    w.kind = k;
    w.data = d;
    w.hdr_type = t;
    w.path = r;
    w.nal_len = 24'(nl);
    w.frame_len = 24'(fl);
    w.write_ok = ws;
    w.key = key;
    w.changed = ch;
    w.sps_word = sps_word;
    w.last_of_word = 1'b0;
    expected_words.push_back(w);
  endfunction

  // one byte enters the open nal; sps bytes 1..3 are captured
  function automatic void commit_byte(logic [7:0] b);
    route_e r;
    r = path_for_type(open_type);
    if (open_type == TYPE_SPS && open_len >= 1 && open_len <= 3)
      sps_word[8 * (3 - int'(open_len)) +: 8] = b;
    open_len = sat_len(open_len, 1);
    if (r != ROUTE_DROP) add_record(KIND_BYTE, b, open_type, r, 0, 0, 0, 0, 0);
  endfunction

  function automatic void release_held();
    for (int i = 0; i < int'(hold_n) && i < 3; i++) commit_byte(zero_hold[i]);
    hold_n = 0;
  endfunction

  function automatic void close_nal();
    route_e r;
    r = path_for_type(open_type);
    if (r == ROUTE_SAMPLE) begin
      unit_bytes = sat_len(unit_bytes, sat_len(4, open_len));
    end else if (r == ROUTE_SPS) begin
      have_sps = 1'b1;
      unit_params = 1'b1;
    end else if (r == ROUTE_PPS) begin
      have_pps = 1'b1;
      unit_params = 1'b1;
    end
    if (r != ROUTE_DROP) add_record(KIND_NAL_END, 8'h00, open_type, r, open_len, 0, 0, 0, 0);
    open_len = 0;
  endfunction

  // expected results of one accepted word
  function automatic void predict_word(logic [7:0] b, logic is_last, logic key);
    int      before_n;
    bit      ws;
    record_t w;
    before_n = expected_words.size();
    case (scan)
      PH_HEADER: begin
        open_type = 5'(b & TYPE_MASK);
        open_len = 0;
        if (open_type == TYPE_SPS) sps_word = '0;
        commit_byte(b);
        hold_n = 0;
        scan = PH_INSIDE;
      end
      PH_INSIDE: begin
        if (b == 8'h00) begin
          // a fourth zero pushes the oldest held zero into the nal
          if (hold_n >= 3) begin
            commit_byte(zero_hold[0]);
            zero_hold[0] = zero_hold[1];
            zero_hold[1] = zero_hold[2];
            hold_n = 2;
          end
          zero_hold[hold_n] = 8'h00;
          hold_n++;
        end else if (b == 8'h01 && hold_n >= 2) begin
          hold_n = 0;
          close_nal();
          scan = PH_HEADER;
        end else begin
          release_held();
          commit_byte(b);
        end
      end
      default: begin
        scan = PH_SEARCH;
        if (b == 8'h00) begin
          hold_n = (hold_n < 2) ? hold_n + 1 : 2;
        end else if (b == 8'h01 && hold_n >= 2) begin
          hold_n = 0;
          scan = PH_HEADER;
        end else begin
          hold_n = 0;
        end
      end
    endcase

    // access unit end closes any open nal first
    if (is_last) begin
      if (scan == PH_INSIDE) begin
        release_held();
        close_nal();
      end
      ws = (unit_bytes != 0) && have_sps && have_pps;
      add_record(KIND_UNIT_END, 8'h00, 5'd0, ROUTE_SAMPLE, 0, unit_bytes, ws, key, unit_params);
      scan = PH_SEARCH;
      hold_n = 0;
      unit_bytes = 0;
      unit_params = 1'b0;
      open_len = 0;
      open_type = '0;
    end

    if (expected_words.size() > before_n) begin
      w = expected_words.pop_back();
      w.last_of_word = 1'b1;
      expected_words.push_back(w);
    end
  endfunction

  // compare one popped word against the oldest expectation
  task automatic check_word();
    record_t w;
    string   diff;
    diff = "";
    if (expected_words.size() == 0) begin
      report($sformatf("word with nothing expected: kind %0d byte %h", kind_o, out_byte_o));
    end else begin
      w = expected_words.pop_front();
      if (kind_o !== w.kind) diff = {diff, " kind"};
      if (out_byte_o !== w.data) diff = {diff, " byte"};
      if (unit_type_o !== w.hdr_type) diff = {diff, " type"};
      if (route_o !== w.path) diff = {diff, " route"};
      if (nal_length_o !== w.nal_len) diff = {diff, " nal_len"};
      if (frame_length_o !== w.frame_len) diff = {diff, " frame_len"};
      if (write_sample_o !== w.write_ok) diff = {diff, " write"};
      if (key_out_o !== w.key) diff = {diff, " key"};
      if (params_changed_o !== w.changed) diff = {diff, " changed"};
      if (sps_info_o !== w.sps_word) diff = {diff, " sps"};
      if (run_last_o !== w.last_of_word) diff = {diff, " run_last"};
      if (diff != "")
        report($sformatf("bad%s: got k%0d b%h t%0d r%0d nl%0d fl%0d w%b k%b c%b s%h l%b, exp %p",
                         diff, kind_o, out_byte_o, unit_type_o, route_o, nal_length_o,
                         frame_length_o, write_sample_o, key_out_o, params_changed_o,
                         sps_info_o, run_last_o, w));
      case (w.kind)
        KIND_BYTE:    n_payload++;
        KIND_NAL_END: n_nal_end++;
        default: begin
          n_unit_end++;
          if (w.write_ok) n_written++;
        end
      endcase
    end
  endtask

  // result side: check on accept, then pick the next pop from a changing stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) check_word();
    pop_cycle++;
    if (pop_cycle % 50 == 0) pop_mode = $urandom_range(0, 2);
    case (pop_mode)
      0: pop_i <= 1'b1;
      1: pop_i <= 1'($urandom_range(0, 1));
      default: begin
        if (pop_hold > 0) begin
          pop_hold--;
          pop_i <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          pop_hold = $urandom_range(3, 12);
          pop_i <= 1'b0;
        end else begin
          pop_i <= 1'b1;
        end
      end
    endcase
  end

  // one word in; bursts of random length with random gaps unless steady
  task automatic send_word(input logic [7:0] b, input logic is_last, input logic key);
    int gap;
    push_i      <= 1'b1;
    data_byte_i <= b;
    unit_last_i <= is_last;
    key_frame_i <= key;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    words_sent++;
    predict_word(b, is_last, key);
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(1, 6);
        push_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // the bytes of stream_q as one access unit
  task automatic send_stream(input logic key);
    int n;
    n = stream_q.size();
    for (int i = 0; i < n; i++)
      send_word(stream_q[i], i == n - 1, (i == n - 1) ? key : 1'($urandom_range(0, 1)));
    units_sent++;
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // junk with no start code, then unit end
  task automatic test_no_start_code();
    stream_q = '{8'hFF, 8'h00};
    send_stream(1'b1);
  endtask

  // sps, four-byte start code, pps, sei, slice ending on held zeros
  task automatic test_full_unit();
    stream_q = '{8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'hC0, 8'h1F,
                 8'h00, 8'h00, 8'h00, 8'h01, 8'h68, 8'hCE,
                 8'h00, 8'h00, 8'h01, 8'h06, 8'h05,
                 8'h00, 8'h00, 8'h01, 8'h65, 8'hFF, 8'h00, 8'h00};
    send_stream(1'b1);
  endtask

  // sps cut short by the unit end leaves zeros in the later positions
  task automatic test_short_sps();
    stream_q = '{8'h00, 8'h00, 8'h01, 8'h67, 8'hFF};
    send_stream(1'b0);
  endtask

  // unit ends directly after a start code
  task automatic test_end_after_start_code();
    stream_q = '{8'h00, 8'h00, 8'h01};
    send_stream(1'b1);
  endtask

  // well-formed unit with random nals, or noise
  task automatic build_unit();
    int n_nals;
    int len;
    int t;
    int zeros;
    stream_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 2))
          0: stream_q.push_back(8'h00);
          1: stream_q.push_back(8'h01);
          default: stream_q.push_back(8'($urandom));
        endcase
      end
    end else begin
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 4)) stream_q.push_back(8'($urandom));
      n_nals = $urandom_range(1, 5);
      repeat (n_nals) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: zeros = 2;
          6, 7, 8: zeros = 3;
          default: zeros = $urandom_range(4, 6);
        endcase
        repeat (zeros) stream_q.push_back(8'h00);
        stream_q.push_back(8'h01);
        case ($urandom_range(0, 9))
          0, 1: t = TYPE_SPS;
          2: t = TYPE_PPS;
          3: t = TYPE_SEI;
          4: t = 5;
          5: t = 1;
          default: t = $urandom_range(0, 31);
        endcase
        stream_q.push_back({3'($urandom), 5'(t)});
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0: stream_q.push_back(8'h00);
            1: stream_q.push_back(8'($urandom_range(0, 3)));
            default: stream_q.push_back(8'($urandom));
          endcase
        end
      end
      // trailing zeros or a dangling start code at the unit end
      case ($urandom_range(0, 5))
        0: repeat ($urandom_range(1, 4)) stream_q.push_back(8'h00);
        1: begin
          stream_q.push_back(8'h00);
          stream_q.push_back(8'h00);
          stream_q.push_back(8'h01);
        end
        default: ;
      endcase
      if (stream_q.size() == 0) stream_q.push_back(8'h00);
    end
  endtask

  task automatic test_random_units(input int target);
    int start_words;
    start_words = words_sent;
    while (words_sent - start_words < target) begin
      build_unit();
      steady = ($urandom_range(0, 3) == 0);
      send_stream(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_start_code();
    test_full_unit();
    test_short_sps();
    test_end_after_start_code();
    wait_drained();
    test_random_units(210);

    // drain and let any stray word show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_words.size() != 0)
      report($sformatf("%0d words never arrived", expected_words.size()));

    $display("sent %0d bytes in %0d access units", words_sent, units_sent);
    $display("checked %0d payload bytes, %0d nal ends, %0d unit ends (%0d written)",
             n_payload, n_nal_end, n_unit_end, n_written);
    if (errors == 0) begin
      $display("tb_annexb_to_avcc_nal_splitter OK");
    end else begin
      $display("tb_annexb_to_avcc_nal_splitter NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout with %0d words outstanding", expected_words.size());
    $display("tb_annexb_to_avcc_nal_splitter NOT OK");
    $finish;
  end

endmodule
